// ===== rtl/cromap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_pkg
// Shared types and constants for the chained range offset map.
// ----------------------------------------------------------------------------
package cromap_pkg;

   localparam int STAGE_COUNT_DEF       = 7;
   localparam int ENTRIES_PER_STAGE_DEF = 32;
   localparam int INTERVAL_SLOTS_DEF    = 16;

   localparam int VALUE_W     = 32;
   localparam int STAGE_REGS  = 7;
   localparam int CNT_W       = 6;
   localparam int ICNT_W      = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // register index of the seed interval count; stage counts sit below it
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_COUNT = CSR_INDEX_W'(STAGE_REGS);

   typedef enum logic [1:0] {
      FUNC_LOAD_RANGE    = 2'd0,
      FUNC_LOAD_INTERVAL = 2'd1,
      FUNC_FORWARD       = 2'd2,
      FUNC_REVERSE       = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STAGE,
      ST_RANGE_CHK,
      ST_SEED,
      ST_SEED_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [STAGE_REGS-1:0][CNT_W-1:0] stage_cnt;
      logic [ICNT_W-1:0]                intv_cnt;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_W-1:0] dest;
      logic [VALUE_W-1:0] src;
      logic [VALUE_W-1:0] len;
   } range_entry_type;

   typedef struct packed {
      logic [VALUE_W-1:0] start;
      logic [VALUE_W-1:0] len;
   } interval_entry_type;

endpackage
`default_nettype wire

// ===== rtl/cromap_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_req_if
// Request channel: table loads and translation queries.
// ----------------------------------------------------------------------------
interface cromap_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [2:0]  stage;
   logic [4:0]  slot;
   logic [31:0] dest_base;
   logic [31:0] source_base;
   logic [31:0] span_length;
   logic [31:0] query_value;

   modport source (output valid, func, stage, slot, dest_base, source_base,
                   span_length, query_value, input ready);
   modport sink   (input valid, func, stage, slot, dest_base, source_base,
                   span_length, query_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/cromap_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_rsp_if
// Response channel: translated value and flags.
// ----------------------------------------------------------------------------
interface cromap_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] result_value;
   logic        in_seed_interval;
   logic        overflow;

   modport source (output valid, result_value, in_seed_interval, overflow,
                   input ready);
   modport sink   (input valid, result_value, in_seed_interval, overflow,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/cromap_csr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_csr_if
// Register write channel: index and write data.
// ----------------------------------------------------------------------------
interface cromap_csr_if;
   import cromap_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cromap_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cromap_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/cromap_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_csr
// Entry count registers for the stage tables and the seed interval table.
// ----------------------------------------------------------------------------
module cromap_csr import cromap_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   cromap_csr_if.sink csr_chan,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         if (csr_chan.index < CSR_INTERVAL_COUNT) begin
            cfg_in.stage_cnt[csr_chan.index[2:0]] = csr_chan.data[CNT_W-1:0];
         end else if (csr_chan.index == CSR_INTERVAL_COUNT) begin
            cfg_in.intv_cnt = csr_chan.data[ICNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/cromap_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cromap_seq
// Request sequencer: table writes, stage-by-stage entry scan, seed scan and
// response register.
// ----------------------------------------------------------------------------
module cromap_seq import cromap_pkg::*; #(
   parameter int STAGE_COUNT       = STAGE_COUNT_DEF,
   parameter int ENTRIES_PER_STAGE = ENTRIES_PER_STAGE_DEF,
   parameter int INTERVAL_SLOTS    = INTERVAL_SLOTS_DEF,
   localparam int RDEPTH = STAGE_COUNT * ENTRIES_PER_STAGE,
   localparam int AW     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1,
   localparam int IW     = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cromap_req_if.sink                 req_chan,
   cromap_rsp_if.source               rsp_chan,
   input  wire cfg_type               cfg,
   output logic                       rng_wr_en,
   output logic [AW-1:0]              rng_wr_addr,
   output range_entry_type            rng_wr_data,
   output logic                       rng_rd_en,
   output logic [AW-1:0]              rng_rd_addr,
   input  wire range_entry_type       rng_rd_data,
   output logic                       itv_wr_en,
   output logic [IW-1:0]              itv_wr_addr,
   output interval_entry_type         itv_wr_data,
   output logic                       itv_rd_en,
   output logic [IW-1:0]              itv_rd_addr,
   input  wire interval_entry_type    itv_rd_data
);

   localparam int SW  = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
   localparam int CW  = $clog2(ENTRIES_PER_STAGE + 1);
   localparam int ICW = $clog2(INTERVAL_SLOTS + 1);
   localparam logic [SW-1:0] LAST_STAGE = SW'(STAGE_COUNT - 1);
   localparam logic [AW-1:0] LAST_BASE  = AW'((STAGE_COUNT - 1) * ENTRIES_PER_STAGE);
   localparam logic [AW-1:0] STAGE_STEP = AW'(ENTRIES_PER_STAGE);

   state_type          state_ff, state_in;
   logic               reverse_ff, reverse_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               ovf_ff, ovf_in;
   logic               hit_ff, hit_in;
   logic [SW-1:0]      stage_ff, stage_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [ICW-1:0]     sidx_ff, sidx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               req_take;
   func_type           func;
   logic [CNT_W-1:0]   cnt_raw;
   logic [CW-1:0]      rng_limit;
   logic [ICW-1:0]     itv_limit;
   logic [CW-1:0]      idx_next;
   logic [ICW-1:0]     sidx_next;
   logic [VALUE_W-1:0] span_from;
   logic [VALUE_W-1:0] span_to;
   logic [VALUE_W:0]   span_end;
   logic [VALUE_W:0]   mapped;
   logic               rng_match;
   logic [VALUE_W:0]   itv_end;
   logic               itv_match;
   logic               advance;

   assign func     = func_type'(req_chan.func);
   assign req_take = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // entry count of the current stage and the seed interval count, each clamped to its table size
   always_comb begin
      cnt_raw = '0;
      for (int k = 0; k < STAGE_REGS; k++) begin
         if (int'(stage_ff) == k) begin
            cnt_raw = cfg.stage_cnt[k];
         end
      end
      if (int'(cnt_raw) > ENTRIES_PER_STAGE) begin
         rng_limit = CW'(ENTRIES_PER_STAGE);
      end else begin
         rng_limit = CW'(cnt_raw);
      end
      if (int'(cfg.intv_cnt) > INTERVAL_SLOTS) begin
         itv_limit = ICW'(INTERVAL_SLOTS);
      end else begin
         itv_limit = ICW'(cfg.intv_cnt);
      end
   end

   assign idx_next  = idx_ff + CW'(1);
   assign sidx_next = sidx_ff + ICW'(1);

   // one range entry against the running value
   assign span_from = reverse_ff ? rng_rd_data.dest : rng_rd_data.src;
   assign span_to   = reverse_ff ? rng_rd_data.src  : rng_rd_data.dest;
   assign span_end  = {1'b0, span_from} + {1'b0, rng_rd_data.len};
   assign rng_match = (value_ff >= span_from) && ({1'b0, value_ff} < span_end);
   assign mapped    = {1'b0, value_ff - span_from} + {1'b0, span_to};

   assign itv_end   = {1'b0, itv_rd_data.start} + {1'b0, itv_rd_data.len};
   assign itv_match = (value_ff >= itv_rd_data.start) && ({1'b0, value_ff} < itv_end);

   always_comb begin
      state_in     = state_ff;
      reverse_in   = reverse_ff;
      value_in     = value_ff;
      ovf_in       = ovf_ff;
      hit_in       = hit_ff;
      stage_in     = stage_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      sidx_in      = sidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      advance      = 1'b0;

      rng_wr_en   = 1'b0;
      rng_wr_addr = AW'(req_chan.slot) + AW'(req_chan.stage) * STAGE_STEP;
      rng_wr_data = '{dest: req_chan.dest_base, src: req_chan.source_base,
                      len: req_chan.span_length};
      itv_wr_en   = 1'b0;
      itv_wr_addr = IW'(req_chan.slot);
      itv_wr_data = '{start: req_chan.source_base, len: req_chan.span_length};
      rng_rd_en   = 1'b0;
      rng_rd_addr = base_ff;
      itv_rd_en   = 1'b0;
      itv_rd_addr = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (func)
                  FUNC_LOAD_RANGE: begin
                     rng_wr_en = (int'(req_chan.stage) < STAGE_COUNT) &&
                                 (int'(req_chan.slot) < ENTRIES_PER_STAGE);
                  end
                  FUNC_LOAD_INTERVAL: begin
                     itv_wr_en = (int'(req_chan.slot) < INTERVAL_SLOTS);
                  end
                  FUNC_FORWARD, FUNC_REVERSE: begin
                     reverse_in = (func == FUNC_REVERSE);
                     value_in   = req_chan.query_value;
                     ovf_in     = 1'b0;
                     hit_in     = 1'b0;
                     stage_in   = (func == FUNC_REVERSE) ? LAST_STAGE : '0;
                     base_in    = (func == FUNC_REVERSE) ? LAST_BASE : '0;
                     state_in   = ST_STAGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_STAGE: begin
            if (rng_limit == '0) begin
               advance = 1'b1;
            end else begin
               rng_rd_en   = 1'b1;
               rng_rd_addr = base_ff;
               idx_in      = '0;
               state_in    = ST_RANGE_CHK;
            end
         end
         ST_RANGE_CHK: begin
            if (rng_match) begin
               // saturate on overflow and carry on to the next stage
               if (mapped[VALUE_W]) begin
                  value_in = '1;
                  ovf_in   = 1'b1;
               end else begin
                  value_in = mapped[VALUE_W-1:0];
               end
               advance = 1'b1;
            end else if (idx_next < rng_limit) begin
               rng_rd_en   = 1'b1;
               rng_rd_addr = base_ff + AW'(idx_next);
               idx_in      = idx_next;
            end else begin
               advance = 1'b1;
            end
         end
         ST_SEED: begin
            if (itv_limit == '0) begin
               state_in = ST_DONE;
            end else begin
               itv_rd_en   = 1'b1;
               itv_rd_addr = '0;
               sidx_in     = '0;
               state_in    = ST_SEED_CHK;
            end
         end
         ST_SEED_CHK: begin
            if (itv_match) begin
               hit_in   = 1'b1;
               state_in = ST_DONE;
            end else if (sidx_next < itv_limit) begin
               itv_rd_en   = 1'b1;
               itv_rd_addr = IW'(sidx_next);
               sidx_in     = sidx_next;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_hit_in   = hit_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (reverse_ff) begin
            if (stage_ff == '0) begin
               state_in = ST_SEED;
            end else begin
               stage_in = stage_ff - SW'(1);
               base_in  = base_ff - STAGE_STEP;
               state_in = ST_STAGE;
            end
         end else begin
            if (stage_ff == LAST_STAGE) begin
               state_in = ST_DONE;
            end else begin
               stage_in = stage_ff + SW'(1);
               base_in  = base_ff + STAGE_STEP;
               state_in = ST_STAGE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reverse_ff   <= reverse_in;
      value_ff     <= value_in;
      ovf_ff       <= ovf_in;
      hit_ff       <= hit_in;
      stage_ff     <= stage_in;
      base_ff      <= base_in;
      idx_ff       <= idx_in;
      sidx_ff      <= sidx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_value     = rsp_value_ff;
   assign rsp_chan.in_seed_interval = rsp_hit_ff;
   assign rsp_chan.overflow         = rsp_ovf_ff;

endmodule
`default_nettype wire

// ===== rtl/chained_range_offset_map_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// chained_range_offset_map_top
// Chained range offset map: stage tables of offset entries and seed intervals.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one request per valid/ready handshake: load a range entry,
//   load a seed interval, or run a forward or reverse translation.
//   rsp_chan returns one response per translation; loads return nothing.
//   csr_chan writes the per-stage entry counts (index 0..6) and the seed
//   interval count (index 7); it is always ready.
// Scan:
//   A load is written to its table as it is accepted. A translation scans
//   the stage tables one entry per cycle from the range RAM's single read
//   port: per stage, a start state issues the first read, then entries are
//   checked in turn up to the first hit (an empty stage is skipped).
//   A reverse query then scans the seed intervals, one per cycle. ST_DONE
//   moves the result into the response register once that register is free.
//   One request is in progress at a time.
// Reset and stall:
//   Reset clears the counts and the sequencer; table contents are undefined
//   until written. A stalled response holds in its register; the next request
//   is accepted meanwhile and its result waits until the register drains.
// ----------------------------------------------------------------------------
module chained_range_offset_map_top import cromap_pkg::*; #(
   parameter int STAGE_COUNT       = STAGE_COUNT_DEF,
   parameter int ENTRIES_PER_STAGE = ENTRIES_PER_STAGE_DEF,
   parameter int INTERVAL_SLOTS    = INTERVAL_SLOTS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   cromap_req_if.sink   req_chan,
   cromap_rsp_if.source rsp_chan,
   cromap_csr_if.sink   csr_chan
);

   localparam int RDEPTH = STAGE_COUNT * ENTRIES_PER_STAGE;
   localparam int AW     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int IW     = (INTERVAL_SLOTS > 1) ? $clog2(INTERVAL_SLOTS) : 1;

   cfg_type            cfg;
   logic               rng_wr_en;
   logic [AW-1:0]      rng_wr_addr;
   range_entry_type    rng_wr_data;
   logic               rng_rd_en;
   logic [AW-1:0]      rng_rd_addr;
   range_entry_type    rng_rd_data;
   logic               itv_wr_en;
   logic [IW-1:0]      itv_wr_addr;
   interval_entry_type itv_wr_data;
   logic               itv_rd_en;
   logic [IW-1:0]      itv_rd_addr;
   interval_entry_type itv_rd_data;

   cromap_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   cromap_ram #(
      .WIDTH ($bits(range_entry_type)),
      .DEPTH (RDEPTH)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (rng_wr_en),
      .wr_addr (rng_wr_addr),
      .wr_data (rng_wr_data),
      .rd_en   (rng_rd_en),
      .rd_addr (rng_rd_addr),
      .rd_data (rng_rd_data)
   );

   cromap_ram #(
      .WIDTH ($bits(interval_entry_type)),
      .DEPTH (INTERVAL_SLOTS)
   ) u_interval_ram (
      .clock   (clock),
      .wr_en   (itv_wr_en),
      .wr_addr (itv_wr_addr),
      .wr_data (itv_wr_data),
      .rd_en   (itv_rd_en),
      .rd_addr (itv_rd_addr),
      .rd_data (itv_rd_data)
   );

   cromap_seq #(
      .STAGE_COUNT       (STAGE_COUNT),
      .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE),
      .INTERVAL_SLOTS    (INTERVAL_SLOTS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .cfg         (cfg),
      .rng_wr_en   (rng_wr_en),
      .rng_wr_addr (rng_wr_addr),
      .rng_wr_data (rng_wr_data),
      .rng_rd_en   (rng_rd_en),
      .rng_rd_addr (rng_rd_addr),
      .rng_rd_data (rng_rd_data),
      .itv_wr_en   (itv_wr_en),
      .itv_wr_addr (itv_wr_addr),
      .itv_wr_data (itv_wr_data),
      .itv_rd_en   (itv_rd_en),
      .itv_rd_addr (itv_rd_addr),
      .itv_rd_data (itv_rd_data)
   );

endmodule
`default_nettype wire
